[rtl/symmetric_4x4_adjugate_determinant_assert.svh]
// ----------------------------------------------------------------------------
// Symmetric 4x4 adjugate and determinant: assertion macros
// Shared macros for concurrent checks clocked on clk and muted in reset.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_4X4_ADJUGATE_DETERMINANT_ASSERT_SVH
`define SYMMETRIC_4X4_ADJUGATE_DETERMINANT_ASSERT_SVH

// Overlapping implication: the consequent is checked in the same cycle.
`define SADJ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication: the consequent is checked in the next cycle.
`define SADJ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sadj_pkg.sv]
// ----------------------------------------------------------------------------
// Symmetric 4x4 adjugate and determinant: package
// Widths, pipeline depth and the index tables of the cofactor datapath.
// ----------------------------------------------------------------------------
package sadj_pkg;

  localparam int ENTRY_WIDTH_DEF = 14;
  localparam int SCALE_WIDTH     = 16;
  localparam int DET_OUT_WIDTH   = 64;
  localparam int NUM_ENTRIES     = 10;
  localparam int NUM_MINORS      = 12;
  localparam int NUM_DET_TERMS   = 6;
  localparam int TERMS_PER_ADJ   = 3;
  localparam int LATENCY         = 6;

  localparam logic [DET_OUT_WIDTH-1:0] DET_MAX = {1'b0, {(DET_OUT_WIDTH-1){1'b1}}};
  localparam logic [DET_OUT_WIDTH-1:0] DET_MIN = {1'b1, {(DET_OUT_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [1:0] r0;
    logic [1:0] c0;
    logic [1:0] r1;
    logic [1:0] c1;
    logic [1:0] r2;
    logic [1:0] c2;
    logic [1:0] r3;
    logic [1:0] c3;
  } minor_sel_t;

  typedef struct packed {
    logic [1:0] r;
    logic [1:0] c;
    logic [3:0] mi;
    logic       neg;
  } adj_term_t;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic       neg;
  } det_term_t;

  // Row and column of each upper-triangle input entry.
  localparam logic [1:0] ENTRY_ROW [NUM_ENTRIES] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3
  };
  localparam logic [1:0] ENTRY_COL [NUM_ENTRIES] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3
  };

  // The first six are 2x2 minors of rows 0 and 1, the last six of rows 2 and 3.
  localparam minor_sel_t MINOR_SEL [NUM_MINORS] = '{
    '{2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1, 2'd0},
    '{2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd0, 2'd1, 2'd3, 2'd0, 2'd3, 2'd1, 2'd0},
    '{2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd1},
    '{2'd0, 2'd1, 2'd1, 2'd3, 2'd0, 2'd3, 2'd1, 2'd1},
    '{2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2},
    '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd0},
    '{2'd2, 2'd0, 2'd3, 2'd2, 2'd2, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd0, 2'd3, 2'd3, 2'd2, 2'd3, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd2, 2'd3, 2'd1},
    '{2'd2, 2'd1, 2'd3, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1},
    '{2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd3, 2'd2}
  };

  // Each adjugate entry is a signed sum of three entry-by-minor products.
  localparam adj_term_t ADJ_TERMS [NUM_ENTRIES][TERMS_PER_ADJ] = '{
    '{'{2'd1, 2'd1, 4'd11, 1'b0}, '{2'd1, 2'd2, 4'd10, 1'b1}, '{2'd1, 2'd3, 4'd9, 1'b0}},
    '{'{2'd0, 2'd1, 4'd11, 1'b1}, '{2'd0, 2'd2, 4'd10, 1'b0}, '{2'd0, 2'd3, 4'd9, 1'b1}},
    '{'{2'd3, 2'd1, 4'd5,  1'b0}, '{2'd3, 2'd2, 4'd4,  1'b1}, '{2'd3, 2'd3, 4'd3, 1'b0}},
    '{'{2'd2, 2'd1, 4'd5,  1'b1}, '{2'd2, 2'd2, 4'd4,  1'b0}, '{2'd2, 2'd3, 4'd3, 1'b1}},
    '{'{2'd0, 2'd0, 4'd11, 1'b0}, '{2'd0, 2'd2, 4'd8,  1'b1}, '{2'd0, 2'd3, 4'd7, 1'b0}},
    '{'{2'd3, 2'd0, 4'd5,  1'b1}, '{2'd3, 2'd2, 4'd2,  1'b0}, '{2'd3, 2'd3, 4'd1, 1'b1}},
    '{'{2'd2, 2'd0, 4'd5,  1'b0}, '{2'd2, 2'd2, 4'd2,  1'b1}, '{2'd2, 2'd3, 4'd1, 1'b0}},
    '{'{2'd3, 2'd0, 4'd4,  1'b0}, '{2'd3, 2'd1, 4'd2,  1'b1}, '{2'd3, 2'd3, 4'd0, 1'b0}},
    '{'{2'd2, 2'd0, 4'd4,  1'b1}, '{2'd2, 2'd1, 4'd2,  1'b0}, '{2'd2, 2'd3, 4'd0, 1'b1}},
    '{'{2'd2, 2'd0, 4'd3,  1'b0}, '{2'd2, 2'd1, 4'd1,  1'b1}, '{2'd2, 2'd2, 4'd0, 1'b0}}
  };

  // The determinant as a signed sum of products of complementary minors.
  localparam det_term_t DET_TERMS [NUM_DET_TERMS] = '{
    '{4'd0, 4'd11, 1'b0},
    '{4'd1, 4'd10, 1'b1},
    '{4'd2, 4'd9,  1'b0},
    '{4'd3, 4'd8,  1'b0},
    '{4'd4, 4'd7,  1'b1},
    '{4'd5, 4'd6,  1'b0}
  };

endpackage

[rtl/symmetric_4x4_adjugate_determinant.sv]
// ----------------------------------------------------------------------------
// Symmetric 4x4 adjugate and determinant
// Computes the upper triangle of the adjugate of a symmetric 4x4 matrix and
// its determinant times a programmable scale, saturated to signed 64 bits.
//
//   Channel   Handshake            Payload
//   input     start / busy         in_m00 .. in_m33
//   result    out_valid (strobe)   out_adj_00 .. out_adj_33, out_det_scaled
//   config    cfg_we               cfg_wdata (det_scale)
//
// A matrix transfer can take place in every cycle while busy is low; busy is high in reset and
// in the first cycle after it.
// Each result passes through six register stages after its transfer:
// inputs, 2x2 minors, products, sums, scale products, saturation.
// Reset clears the valid bits and sets det_scale to one.
// The receiver cannot stall, so each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module symmetric_4x4_adjugate_determinant
  import sadj_pkg::*;
#(
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ENTRY_WIDTH-1:0]   in_m00,
  input  logic signed [ENTRY_WIDTH-1:0]   in_m01,
  input  logic signed [ENTRY_WIDTH-1:0]   in_m02,
  input  logic signed [ENTRY_WIDTH-1:0]   in_m03,
  input  logic signed [ENTRY_WIDTH-1:0]   in_m11,
  input  logic signed [ENTRY_WIDTH-1:0]   in_m12,
  input  logic signed [ENTRY_WIDTH-1:0]   in_m13,
  input  logic signed [ENTRY_WIDTH-1:0]   in_m22,
  input  logic signed [ENTRY_WIDTH-1:0]   in_m23,
  input  logic signed [ENTRY_WIDTH-1:0]   in_m33,
  output logic                            out_valid,
  output logic signed [3*ENTRY_WIDTH:0]   out_adj_00,
  output logic signed [3*ENTRY_WIDTH:0]   out_adj_01,
  output logic signed [3*ENTRY_WIDTH:0]   out_adj_02,
  output logic signed [3*ENTRY_WIDTH:0]   out_adj_03,
  output logic signed [3*ENTRY_WIDTH:0]   out_adj_11,
  output logic signed [3*ENTRY_WIDTH:0]   out_adj_12,
  output logic signed [3*ENTRY_WIDTH:0]   out_adj_13,
  output logic signed [3*ENTRY_WIDTH:0]   out_adj_22,
  output logic signed [3*ENTRY_WIDTH:0]   out_adj_23,
  output logic signed [3*ENTRY_WIDTH:0]   out_adj_33,
  output logic signed [DET_OUT_WIDTH-1:0] out_det_scaled,
  input  logic                            cfg_we,
  input  logic signed [SCALE_WIDTH-1:0]   cfg_wdata
);

  localparam int PAIR_W    = 2 * ENTRY_WIDTH;
  localparam int MINOR_W   = 2 * ENTRY_WIDTH + 1;
  localparam int ADJ_W     = 3 * ENTRY_WIDTH + 1;
  localparam int DET_W     = 4 * ENTRY_WIDTH + 2;
  localparam int ADJ_SUM_W = ADJ_W + 2;
  localparam int DET_SUM_W = DET_W + 3;
  localparam int LO_W      = DET_W / 2;
  localparam int HI_W      = DET_W - LO_W;
  localparam int PLO_W     = LO_W + 1 + SCALE_WIDTH;
  localparam int PHI_W     = HI_W + SCALE_WIDTH;
  localparam int FULL_W    = (DET_W + SCALE_WIDTH > DET_OUT_WIDTH) ?
                             (DET_W + SCALE_WIDTH) : (DET_OUT_WIDTH + 1);

  logic                          busy_r;
  logic                          accept;
  logic [LATENCY-1:0]            vld_r;
  logic signed [SCALE_WIDTH-1:0] det_scale_r;

  logic signed [ENTRY_WIDTH-1:0] e1_r [NUM_ENTRIES];
  logic signed [ENTRY_WIDTH-1:0] m1 [4][4];
  logic signed [MINOR_W-1:0]     minor2_nxt [NUM_MINORS];
  logic signed [MINOR_W-1:0]     minor2_r [NUM_MINORS];
  logic signed [ENTRY_WIDTH-1:0] e2_r [NUM_ENTRIES];
  logic signed [ENTRY_WIDTH-1:0] m2 [4][4];

  logic signed [ADJ_W-1:0]       adjp3_nxt [NUM_ENTRIES][TERMS_PER_ADJ];
  logic signed [ADJ_W-1:0]       adjp3_r [NUM_ENTRIES][TERMS_PER_ADJ];
  logic signed [DET_W-1:0]       detp3_nxt [NUM_DET_TERMS];
  logic signed [DET_W-1:0]       detp3_r [NUM_DET_TERMS];

  logic signed [ADJ_W-1:0]       adj4_nxt [NUM_ENTRIES];
  logic signed [ADJ_W-1:0]       adj4_r [NUM_ENTRIES];
  logic signed [DET_W-1:0]       det4_nxt;
  logic signed [DET_W-1:0]       det4_r;

  logic signed [ADJ_W-1:0]       adj5_r [NUM_ENTRIES];
  logic signed [PLO_W-1:0]       plo5_nxt;
  logic signed [PLO_W-1:0]       plo5_r;
  logic signed [PHI_W-1:0]       phi5_nxt;
  logic signed [PHI_W-1:0]       phi5_r;

  logic signed [FULL_W-1:0]      full6;
  logic [FULL_W-DET_OUT_WIDTH:0] top6;
  logic                          ovf6;
  logic [DET_OUT_WIDTH-1:0]      det6_nxt;
  logic [DET_OUT_WIDTH-1:0]      det6_r;
  logic signed [ADJ_W-1:0]       adj6_r [NUM_ENTRIES];

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      vld_r       <= '0;
      det_scale_r <= SCALE_WIDTH'(1);
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[LATENCY-2:0], accept};
      if (cfg_we) begin
        det_scale_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      m1[ENTRY_ROW[k]][ENTRY_COL[k]] = e1_r[k];
      m1[ENTRY_COL[k]][ENTRY_ROW[k]] = e1_r[k];
      m2[ENTRY_ROW[k]][ENTRY_COL[k]] = e2_r[k];
      m2[ENTRY_COL[k]][ENTRY_ROW[k]] = e2_r[k];
    end
  end

  always_comb begin
    minor_sel_t                      sel;
    logic signed [2*ENTRY_WIDTH-1:0] pa;
    logic signed [2*ENTRY_WIDTH-1:0] pb;
    for (int k = 0; k < NUM_MINORS; k++) begin
      sel = MINOR_SEL[k];
      pa  = PAIR_W'(m1[sel.r0][sel.c0]) * PAIR_W'(m1[sel.r1][sel.c1]);
      pb  = PAIR_W'(m1[sel.r2][sel.c2]) * PAIR_W'(m1[sel.r3][sel.c3]);
      minor2_nxt[k] = MINOR_W'(pa) - MINOR_W'(pb);
    end
  end

  always_comb begin
    adj_term_t t;
    det_term_t d;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      for (int j = 0; j < TERMS_PER_ADJ; j++) begin
        t = ADJ_TERMS[i][j];
        adjp3_nxt[i][j] = ADJ_W'(m2[t.r][t.c]) * ADJ_W'(minor2_r[t.mi]);
      end
    end
    for (int k = 0; k < NUM_DET_TERMS; k++) begin
      d = DET_TERMS[k];
      detp3_nxt[k] = DET_W'(minor2_r[d.a]) * DET_W'(minor2_r[d.b]);
    end
  end

  always_comb begin
    logic signed [ADJ_SUM_W-1:0] acc;
    logic signed [ADJ_SUM_W-1:0] p;
    logic signed [DET_SUM_W-1:0] dacc;
    logic signed [DET_SUM_W-1:0] dp;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      acc = '0;
      for (int j = 0; j < TERMS_PER_ADJ; j++) begin
        p   = ADJ_SUM_W'(adjp3_r[i][j]);
        acc = ADJ_TERMS[i][j].neg ? (acc - p) : (acc + p);
      end
      adj4_nxt[i] = acc[ADJ_W-1:0];
    end
    dacc = '0;
    for (int k = 0; k < NUM_DET_TERMS; k++) begin
      dp   = DET_SUM_W'(detp3_r[k]);
      dacc = DET_TERMS[k].neg ? (dacc - dp) : (dacc + dp);
    end
    det4_nxt = dacc[DET_W-1:0];
  end

  assign plo5_nxt = PLO_W'($signed({1'b0, det4_r[LO_W-1:0]})) * PLO_W'(det_scale_r);
  assign phi5_nxt = PHI_W'($signed(det4_r[DET_W-1:LO_W])) * PHI_W'(det_scale_r);

  assign full6 = (FULL_W'(phi5_r) <<< LO_W) + FULL_W'(plo5_r);
  assign top6  = full6[FULL_W-1:DET_OUT_WIDTH-1];
  assign ovf6  = !((&top6) || !(|top6));

  always_comb begin
    if (ovf6) begin
      det6_nxt = full6[FULL_W-1] ? DET_MIN : DET_MAX;
    end else begin
      det6_nxt = full6[DET_OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    e1_r     <= '{in_m00, in_m01, in_m02, in_m03, in_m11,
                  in_m12, in_m13, in_m22, in_m23, in_m33};
    minor2_r <= minor2_nxt;
    e2_r     <= e1_r;
    adjp3_r  <= adjp3_nxt;
    detp3_r  <= detp3_nxt;
    adj4_r   <= adj4_nxt;
    det4_r   <= det4_nxt;
    adj5_r   <= adj4_r;
    plo5_r   <= plo5_nxt;
    phi5_r   <= phi5_nxt;
    adj6_r   <= adj5_r;
    det6_r   <= det6_nxt;
  end

  assign out_valid      = vld_r[LATENCY-1];
  assign out_adj_00     = adj6_r[0];
  assign out_adj_01     = adj6_r[1];
  assign out_adj_02     = adj6_r[2];
  assign out_adj_03     = adj6_r[3];
  assign out_adj_11     = adj6_r[4];
  assign out_adj_12     = adj6_r[5];
  assign out_adj_13     = adj6_r[6];
  assign out_adj_22     = adj6_r[7];
  assign out_adj_23     = adj6_r[8];
  assign out_adj_33     = adj6_r[9];
  assign out_det_scaled = det6_r;

endmodule

[rtl/sadj_checker.sv]
// ----------------------------------------------------------------------------
// Symmetric 4x4 adjugate and determinant: port checker
// Checks transfer timing, busy outside reset and a zero-matrix result on the top-level ports.
// ----------------------------------------------------------------------------
`include "symmetric_4x4_adjugate_determinant_assert.svh"

module sadj_checker
  import sadj_pkg::*;
#(
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic signed [ENTRY_WIDTH-1:0]   in_m00,
  input logic signed [ENTRY_WIDTH-1:0]   in_m01,
  input logic signed [ENTRY_WIDTH-1:0]   in_m02,
  input logic signed [ENTRY_WIDTH-1:0]   in_m03,
  input logic signed [ENTRY_WIDTH-1:0]   in_m11,
  input logic signed [ENTRY_WIDTH-1:0]   in_m12,
  input logic signed [ENTRY_WIDTH-1:0]   in_m13,
  input logic signed [ENTRY_WIDTH-1:0]   in_m22,
  input logic signed [ENTRY_WIDTH-1:0]   in_m23,
  input logic signed [ENTRY_WIDTH-1:0]   in_m33,
  input logic                            out_valid,
  input logic signed [3*ENTRY_WIDTH:0]   out_adj_00,
  input logic signed [3*ENTRY_WIDTH:0]   out_adj_01,
  input logic signed [3*ENTRY_WIDTH:0]   out_adj_02,
  input logic signed [3*ENTRY_WIDTH:0]   out_adj_03,
  input logic signed [3*ENTRY_WIDTH:0]   out_adj_11,
  input logic signed [3*ENTRY_WIDTH:0]   out_adj_12,
  input logic signed [3*ENTRY_WIDTH:0]   out_adj_13,
  input logic signed [3*ENTRY_WIDTH:0]   out_adj_22,
  input logic signed [3*ENTRY_WIDTH:0]   out_adj_23,
  input logic signed [3*ENTRY_WIDTH:0]   out_adj_33,
  input logic signed [DET_OUT_WIDTH-1:0] out_det_scaled
);

  logic in_xfer;
  logic in_zero;
  logic out_zero;

  assign in_xfer  = start && !busy;
  assign in_zero  = in_xfer && (in_m00 == '0) && (in_m01 == '0) && (in_m02 == '0) &&
                    (in_m03 == '0) && (in_m11 == '0) && (in_m12 == '0) &&
                    (in_m13 == '0) && (in_m22 == '0) && (in_m23 == '0) &&
                    (in_m33 == '0);
  assign out_zero = (out_adj_00 == '0) && (out_adj_01 == '0) && (out_adj_02 == '0) &&
                    (out_adj_03 == '0) && (out_adj_11 == '0) && (out_adj_12 == '0) &&
                    (out_adj_13 == '0) && (out_adj_22 == '0) && (out_adj_23 == '0) &&
                    (out_adj_33 == '0) && (out_det_scaled == '0);

  `SADJ_ASSERT_IMP(a_xfer_gives_result, in_xfer, ##LATENCY out_valid, "result strobe missing after transfer")
  `SADJ_ASSERT_IMP(a_result_has_xfer, out_valid, $past(in_xfer, LATENCY), "result strobe without transfer")
  `SADJ_ASSERT_IMP(a_zero_matrix, out_valid && $past(in_zero, LATENCY), out_zero, "zero matrix gave nonzero result")
  `SADJ_ASSERT_NXT(a_ready_after_reset, rst_n, !busy, "busy high outside reset")

endmodule

bind symmetric_4x4_adjugate_determinant sadj_checker #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_sadj_checker (.*);

[dv/symmetric_4x4_adjugate_determinant_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Symmetric 4x4 adjugate and determinant testbench
// Sends fixed and random-burst symmetric 4x4 matrices under several det_scale
// settings. An exact cofactor predictor supplies the expected results, and a
// checker compares every strobed result field by field with the oldest one.
// ----------------------------------------------------------------------------
module symmetric_4x4_adjugate_determinant_tb
  import sadj_pkg::*;
();

  localparam int ENTRY_W      = ENTRY_WIDTH_DEF;
  localparam int ADJ_W        = 3 * ENTRY_W + 1;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SHOWN_ERRORS = 10;

  localparam logic [0:9][1:0] UT_ROW = {2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
                                        2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
  localparam logic [0:9][1:0] UT_COL = {2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                        2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
  localparam logic signed [127:0] PROD_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] PROD_LO = -PROD_HI - 128'sd1;

  typedef logic [0:9][ENTRY_W-1:0] matrix_t;

  typedef struct packed {
    logic [0:9][ADJ_W-1:0]           adj;
    logic signed [DET_OUT_WIDTH-1:0] det;
  } adj_det_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [ENTRY_W-1:0] in_m00 = '0, in_m01 = '0, in_m02 = '0, in_m03 = '0;
  logic signed [ENTRY_W-1:0] in_m11 = '0, in_m12 = '0, in_m13 = '0;
  logic signed [ENTRY_W-1:0] in_m22 = '0, in_m23 = '0, in_m33 = '0;
  logic out_valid;
  logic signed [ADJ_W-1:0] out_adj_00, out_adj_01, out_adj_02, out_adj_03;
  logic signed [ADJ_W-1:0] out_adj_11, out_adj_12, out_adj_13;
  logic signed [ADJ_W-1:0] out_adj_22, out_adj_23, out_adj_33;
  logic signed [DET_OUT_WIDTH-1:0] out_det_scaled;
  logic cfg_we = 1'b0;
  logic signed [SCALE_WIDTH-1:0] cfg_wdata = '0;

  logic signed [SCALE_WIDTH-1:0] scale_now = 16'sd1;
  adj_det_t pending_results [$];
  adj_det_t seen, wanted;
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int saturated_count = 0;
  int scale_settings = 1;
  int cycle_count = 0;
  string adj_name [10] = '{"adj_00", "adj_01", "adj_02", "adj_03", "adj_11",
                           "adj_12", "adj_13", "adj_22", "adj_23", "adj_33"};

  symmetric_4x4_adjugate_determinant DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_m00         (in_m00),
    .in_m01         (in_m01),
    .in_m02         (in_m02),
    .in_m03         (in_m03),
    .in_m11         (in_m11),
    .in_m12         (in_m12),
    .in_m13         (in_m13),
    .in_m22         (in_m22),
    .in_m23         (in_m23),
    .in_m33         (in_m33),
    .out_valid      (out_valid),
    .out_adj_00     (out_adj_00),
    .out_adj_01     (out_adj_01),
    .out_adj_02     (out_adj_02),
    .out_adj_03     (out_adj_03),
    .out_adj_11     (out_adj_11),
    .out_adj_12     (out_adj_12),
    .out_adj_13     (out_adj_13),
    .out_adj_22     (out_adj_22),
    .out_adj_23     (out_adj_23),
    .out_adj_33     (out_adj_33),
    .out_det_scaled (out_det_scaled),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic adj_det_t compute_adj_det(matrix_t mt,
                                               logic signed [SCALE_WIDTH-1:0] scale);
    longint a [4][4];
    longint s [3][3];
    longint cof [10];
    longint minor, det;
    logic signed [127:0] wide;
    adj_det_t res;
    int i, j, k, r, c, ri, ci;
    for (k = 0; k < 10; k++) begin
      a[UT_ROW[k]][UT_COL[k]] = $signed(mt[k]);
      a[UT_COL[k]][UT_ROW[k]] = $signed(mt[k]);
    end
    for (k = 0; k < 10; k++) begin
      r = UT_ROW[k];
      c = UT_COL[k];
      ri = 0;
      for (i = 0; i < 4; i++) begin
        if (i != r) begin
          ci = 0;
          for (j = 0; j < 4; j++) begin
            if (j != c) begin
              s[ri][ci] = a[i][j];
              ci++;
            end
          end
          ri++;
        end
      end
      minor = s[0][0] * (s[1][1] * s[2][2] - s[1][2] * s[2][1])
            - s[0][1] * (s[1][0] * s[2][2] - s[1][2] * s[2][0])
            + s[0][2] * (s[1][0] * s[2][1] - s[1][1] * s[2][0]);
      cof[k] = ((r + c) % 2 == 1) ? -minor : minor;
      res.adj[k] = cof[k][ADJ_W-1:0];
    end
    det = a[0][0] * cof[0] + a[0][1] * cof[1] + a[0][2] * cof[2] + a[0][3] * cof[3];
    wide = det;
    wide = wide * scale;
    if (wide > PROD_HI) res.det = DET_MAX;
    else if (wide < PROD_LO) res.det = DET_MIN;
    else res.det = wide[DET_OUT_WIDTH-1:0];
    return res;
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_entry(int mode);
    logic [ENTRY_W-1:0] e;
    case (mode)
      0: e = ENTRY_W'($urandom_range(0, (1 << ENTRY_W) - 1));
      1: begin
        case ($urandom_range(0, 7))
          0: e = ENTRY_W'(-8192);
          1: e = ENTRY_W'(-8191);
          2: e = ENTRY_W'(-1);
          3: e = ENTRY_W'(0);
          4: e = ENTRY_W'(1);
          5: e = ENTRY_W'(8190);
          6: e = ENTRY_W'(8191);
          default: e = 14'h2AAA;
        endcase
      end
      default: e = ENTRY_W'($urandom_range(0, 8) - 4);
    endcase
    return e;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t mt;
    int v [4];
    int k, kind;
    kind = $urandom_range(0, 9);
    for (k = 0; k < 4; k++) v[k] = $urandom_range(0, 180) - 90;
    for (k = 0; k < 10; k++) begin
      case (kind)
        4: mt[k] = rand_entry(1);
        5: mt[k] = rand_entry(2);
        6: mt[k] = (UT_ROW[k] == UT_COL[k]) ? rand_entry(1) : rand_entry(2);
        7: mt[k] = ENTRY_W'(v[UT_ROW[k]] * v[UT_COL[k]]);
        8: mt[k] = rand_entry($urandom_range(0, 2));
        default: mt[k] = rand_entry(0);
      endcase
    end
    return mt;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) $display("ERROR: %s", msg);
  endtask

  // One matrix transfer; start stays high so that a following call can
  // transfer in the next cycle.
  task automatic send_matrix(matrix_t mt);
    adj_det_t expected;
    in_m00 <= mt[0];
    in_m01 <= mt[1];
    in_m02 <= mt[2];
    in_m03 <= mt[3];
    in_m11 <= mt[4];
    in_m12 <= mt[5];
    in_m13 <= mt[6];
    in_m22 <= mt[7];
    in_m23 <= mt[8];
    in_m33 <= mt[9];
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected = compute_adj_det(mt, scale_now);
    if (expected.det == DET_MAX || expected.det == DET_MIN) saturated_count++;
    pending_results.push_back(expected);
    sent_count++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_scale(logic signed [SCALE_WIDTH-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    scale_now = value;
    scale_settings++;
  endtask

  task automatic send_bursts(int n, bit with_gaps);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_matrix(random_matrix());
      left -= burst;
      if (with_gaps && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 10));
    end
  endtask

  task automatic test_reset_scale();
    matrix_t mt;
    mt = '{default: 0};
    send_matrix(mt);
    mt = '{1, 0, 0, 0, 1, 0, 0, 1, 0, 1};
    send_matrix(mt);
    mt = '{default: 8191};
    send_matrix(mt);
    mt = '{default: -8192};
    send_matrix(mt);
    mt = '{8191, 0, 0, 0, 8191, 0, 0, 8191, 0, 8191};
    send_matrix(mt);
    mt = '{-8192, 0, 0, 0, -8192, 0, 0, -8192, 0, -8192};
    send_matrix(mt);
    mt = '{-8192, 8191, -8192, 8191, -8192, 8191, -8192, -8192, 8191, -8192};
    send_matrix(mt);
    mt = '{14'h2AAA, 14'h1555, 14'h2AAA, 14'h1555, 14'h1555,
           14'h2AAA, 14'h1555, 14'h2AAA, 14'h1555, 14'h2AAA};
    send_matrix(mt);
    mt = '{4, 6, 8, 10, 9, 12, 15, 16, 20, 25};
    send_matrix(mt);
    mt = '{8191, -8192, 8191, -8192, 8191, 8191, -8192, -8192, 8191, 8191};
    send_matrix(mt);
  endtask

  task automatic test_det_saturation();
    matrix_t big_pos, big_neg, exact;
    big_pos = '{8191, 0, 0, 0, 8191, 0, 0, 8191, 0, 8191};
    big_neg = '{-8192, 0, 0, 0, 8191, 0, 0, 8191, 0, 8191};
    exact = '{-4096, 0, 0, 0, -4096, 0, 0, -4096, 0, -4096};
    write_scale(16'sh7FFF);
    send_matrix(big_pos);
    send_matrix(big_neg);
    send_matrix(exact);
    write_scale(-16'sh8000);
    send_matrix(big_pos);
    send_matrix(big_neg);
    send_matrix(exact);
  endtask

  task automatic test_zero_scale();
    matrix_t mt;
    write_scale(16'sd0);
    mt = '{8191, 0, 0, 0, 8191, 0, 0, 8191, 0, 8191};
    send_matrix(mt);
    send_matrix(random_matrix());
  endtask

  task automatic test_random_traffic();
    logic signed [SCALE_WIDTH-1:0] scale;
    int phase;
    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0: scale = 16'sh7FFF;
        1: scale = -16'sh8000;
        2: scale = 16'sd0;
        3: scale = -16'sd1;
        4: scale = 16'sd1;
        default: begin
          if ($urandom_range(0, 1) == 1) scale = SCALE_WIDTH'($urandom_range(0, 65535));
          else scale = SCALE_WIDTH'($urandom_range(0, 16) - 8);
        end
      endcase
      write_scale(scale);
      send_bursts(110, phase % 4 != 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      seen.adj[0] = out_adj_00;
      seen.adj[1] = out_adj_01;
      seen.adj[2] = out_adj_02;
      seen.adj[3] = out_adj_03;
      seen.adj[4] = out_adj_11;
      seen.adj[5] = out_adj_12;
      seen.adj[6] = out_adj_13;
      seen.adj[7] = out_adj_22;
      seen.adj[8] = out_adj_23;
      seen.adj[9] = out_adj_33;
      seen.det = out_det_scaled;
      if (pending_results.size() == 0) begin
        flag_error("result strobed with no matrix outstanding");
      end else begin
        wanted = pending_results.pop_front();
        for (int k = 0; k < 10; k++) begin
          if (seen.adj[k] !== wanted.adj[k])
            flag_error($sformatf("result %0d %s: expected %0d, got %0d", checked_count,
                                 adj_name[k], $signed(wanted.adj[k]), $signed(seen.adj[k])));
        end
        if (seen.det !== wanted.det)
          flag_error($sformatf("result %0d det_scaled: expected %0d, got %0d",
                               checked_count, wanted.det, seen.det));
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("symmetric_4x4_adjugate_determinant test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_scale();
    test_det_saturation();
    test_zero_scale();
    test_random_traffic();
    drain_results();
    if (pending_results.size() != 0) flag_error("results missing at end of run");
    $display("Sent %0d matrices under %0d det_scale settings; %0d results checked.",
             sent_count, scale_settings, checked_count);
    $display("%0d determinants saturated; %0d errors found.", saturated_count, error_count);
    if (error_count == 0) begin
      $display("symmetric_4x4_adjugate_determinant test passed");
    end else begin
      $display("symmetric_4x4_adjugate_determinant test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/sadj_pkg.sv
rtl/symmetric_4x4_adjugate_determinant.sv
rtl/sadj_checker.sv
dv/symmetric_4x4_adjugate_determinant_tb.sv
